>>> rtl/cr3_pkg.sv
package cr3_pkg;

  typedef enum logic [1:0] {
    OUT_UNIQUE   = 2'd0,
    OUT_INFINITE = 2'd1,
    OUT_NONE     = 2'd2,
    OUT_SAT      = 2'd3
  } cr3_outcome_e;

  typedef struct packed {
    logic [2:0] neg;
    logic       sing;
    logic       allz;
  } cr3_side_t;

endpackage

>>> rtl/cr3_det.sv
module cr3_det #(
  parameter int W = 32
) (
  input  logic                    clk_i,
  input  logic [3:0]              en_i,
  input  logic signed [W-1:0]     m_i [9],
  output logic signed [3*W+2:0]   det_o
);

  localparam int DETW = 3 * W + 3;

  logic signed [2*W-1:0] p_q  [6];
  logic signed [W-1:0]   a_q  [3];
  logic signed [2*W:0]   t_q  [3];
  logic signed [W-1:0]   b_q  [3];
  logic signed [2*W:0]   lo_q [3];
  logic signed [2*W:0]   hi_q [3];
  logic signed [DETW-1:0] term [3];
  logic signed [DETW-1:0] det_q;

  // cofactor products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0] <= m_i[4] * m_i[8];
      p_q[1] <= m_i[5] * m_i[7];
      p_q[2] <= m_i[3] * m_i[8];
      p_q[3] <= m_i[5] * m_i[6];
      p_q[4] <= m_i[3] * m_i[7];
      p_q[5] <= m_i[4] * m_i[6];
      a_q[0] <= m_i[0];
      a_q[1] <= m_i[1];
      a_q[2] <= m_i[2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int j = 0; j < 3; j++) begin
        t_q[j] <= (2*W+1)'(p_q[2*j]) - (2*W+1)'(p_q[2*j+1]);
        b_q[j] <= a_q[j];
      end
    end
  end

  // minor split into an unsigned low half and a signed high half
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      for (int j = 0; j < 3; j++) begin
        lo_q[j] <= b_q[j] * $signed({1'b0, t_q[j][W-1:0]});
        hi_q[j] <= b_q[j] * $signed(t_q[j][2*W:W]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term[j] = (DETW'(hi_q[j]) <<< W) + DETW'(lo_q[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      det_q <= term[0] - term[1] + term[2];
    end
  end

  assign det_o = det_q;

endmodule

>>> rtl/cr3_div.sv
module cr3_div #(
  parameter int W    = 32,
  parameter int NW   = 115,
  parameter int DENW = 99
) (
  input  logic            clk_i,
  input  logic [W:0]      en_i,
  input  logic [NW-1:0]   num_i,
  input  logic [DENW-1:0] den_i,
  output logic [W-1:0]    q_o,
  output logic            ovf_o
);

  localparam int CW = ((NW > DENW) ? NW : DENW) + W;

  logic [NW-1:0]   rem_q [W+1];
  logic [DENW-1:0] den_q [W+1];
  logic [W-1:0]    q_q   [W+1];
  logic            ovf_q [W+1];

  // quotient at or above 2^W saturates whatever the sign
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      q_q[0]   <= '0;
      ovf_q[0] <= CW'(num_i) >= (CW'(den_i) << W);
    end
  end

  for (genvar s = 1; s <= W; s++) begin : g_step
    localparam int B = W - s;
    logic [CW-1:0] sh;
    logic          ge;
    assign sh = CW'(den_q[s-1]) << B;
    assign ge = CW'(rem_q[s-1]) >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= ge ? (rem_q[s-1] - sh[NW-1:0]) : rem_q[s-1];
        den_q[s] <= den_q[s-1];
        q_q[s]   <= q_q[s-1] | (W'(ge) << B);
        ovf_q[s] <= ovf_q[s-1];
      end
    end
  end

  assign q_o   = q_q[W];
  assign ovf_o = ovf_q[W];

endmodule

>>> rtl/cramer_3x3_solver.sv
// channel   dir  fields (tdata, lowest bit up)
// s_axis    in   c00 c01 c02 k0 c10 c11 c12 k1 c20 c21 c22 k2, DATA_WIDTH each
// m_axis    out  sol_x sol_y sol_z (DATA_WIDTH each), outcome (2 bits)
//
// one item per cycle sustained while m_axis_tready stays high
// the restoring divider resolves one quotient bit per stage
// four determinant stages, one abs stage, one divider setup stage, one output stage
// reset clears only the valid bits of the stages
// each stage advances when it is empty or the next one advances, so a stall
// fills bubbles first and then holds items in place
module cramer_3x3_solver #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // c00 c01 c02 k0 c10 c11 c12 k1 c20 c21 c22 k2
  input  logic [((12*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // sol_x sol_y sol_z outcome
  output logic [((3*DATA_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);
  import cr3_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int DETW = 3 * W + 3;
  localparam int NW   = DETW + FRAC_BITS;
  localparam int NS   = W + 7;
  localparam int SD   = 5;
  localparam int SO   = NS - 1;
  localparam logic [W-1:0] HALF = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  always_comb begin
    en[SO] = !v_q[SO] || m_axis_tready;
    for (int s = SO - 1; s >= 0; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= s_axis_tvalid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = v_q[SO];

  logic signed [W-1:0] fld [12];
  logic signed [W-1:0] mat [4][9];
  logic signed [DETW-1:0] det [4];

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      fld[i] = $signed(s_axis_tdata[i*W +: W]);
    end
    for (int k = 0; k < 4; k++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          mat[k][r*3+c] = (k == c + 1) ? fld[r*4+3] : fld[r*4+c];
        end
      end
    end
  end

  // det[0] main, det[1..3] with a column replaced by the right-hand side
  for (genvar k = 0; k < 4; k++) begin : g_det
    cr3_det #(.W(W)) u_det (
      .clk_i (clk_i),
      .en_i  (en[3:0]),
      .m_i   (mat[k]),
      .det_o (det[k])
    );
  end

  logic [DETW-1:0] dabs_q;
  logic [NW-1:0]   nabs_q [3];
  cr3_side_t       side4_q;
  logic [DETW-1:0] nmag [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nmag[j] = det[j+1][DETW-1] ? DETW'(-det[j+1]) : DETW'(det[j+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      dabs_q <= det[0][DETW-1] ? DETW'(-det[0]) : DETW'(det[0]);
      for (int j = 0; j < 3; j++) begin
        nabs_q[j]      <= NW'(nmag[j]) << FRAC_BITS;
        side4_q.neg[j] <= det[j+1][DETW-1] ^ det[0][DETW-1];
      end
      side4_q.sing <= det[0] == '0;
      side4_q.allz <= (det[1] == '0) && (det[2] == '0) && (det[3] == '0);
    end
  end

  logic [W-1:0] q   [3];
  logic         ovf [3];

  for (genvar j = 0; j < 3; j++) begin : g_div
    cr3_div #(.W(W), .NW(NW), .DENW(DETW)) u_div (
      .clk_i (clk_i),
      .en_i  (en[SD+W:SD]),
      .num_i (nabs_q[j]),
      .den_i (dabs_q),
      .q_o   (q[j]),
      .ovf_o (ovf[j])
    );
  end

  cr3_side_t side_q [W+1];

  always_ff @(posedge clk_i) begin
    if (en[SD]) begin
      side_q[0] <= side4_q;
    end
    for (int s = 1; s <= W; s++) begin
      if (en[SD+s]) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  logic [W-1:0] sol_d [3];
  logic [2:0]   sat;
  cr3_outcome_e oc_d;
  logic [W-1:0] sol_q [3];
  cr3_outcome_e oc_q;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat[j] = ovf[j] || (side_q[W].neg[j] ? (q[j] > HALF) : q[j][W-1]);
      if (side_q[W].sing) begin
        sol_d[j] = '0;
      end else if (sat[j]) begin
        sol_d[j] = side_q[W].neg[j] ? HALF : MAXV;
      end else begin
        sol_d[j] = side_q[W].neg[j] ? -q[j] : q[j];
      end
    end
    if (side_q[W].sing) begin
      oc_d = side_q[W].allz ? OUT_INFINITE : OUT_NONE;
    end else begin
      oc_d = (sat != '0) ? OUT_SAT : OUT_UNIQUE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[SO]) begin
      sol_q <= sol_d;
      oc_q  <= oc_d;
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int j = 0; j < 3; j++) begin
      m_axis_tdata[j*W +: W] = sol_q[j];
    end
    m_axis_tdata[3*W +: 2] = oc_q;
  end

`ifndef SYNTHESIS
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[SO] |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (oc_q == OUT_INFINITE || oc_q == OUT_NONE)
      |-> (sol_q[0] == '0 && sol_q[1] == '0 && sol_q[2] == '0))
    else $error("singular system with nonzero solution");

  a_sat_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && oc_q == OUT_SAT
      |-> (sol_q[0] == HALF || sol_q[0] == MAXV || sol_q[1] == HALF ||
           sol_q[1] == MAXV || sol_q[2] == HALF || sol_q[2] == MAXV))
    else $error("saturated outcome without extreme value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[SO] && !m_axis_tready |=> v_q[SO] && $stable(oc_q))
    else $error("stalled output stage changed");
`endif

endmodule
